// ===== rtl/core/mtdt_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the timer table.
package mtdt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    localparam int ID_W    = 32;
    localparam int DL_W    = 64;
    localparam int DELAY_W = 32;
    localparam int MUL_W   = 20;
    localparam int PROD_W  = DELAY_W + MUL_W;
    localparam int ENTRY_W = ID_W + DL_W;

    localparam logic [MUL_W-1:0] NS_PER_MS  = 20'd1000000;
    localparam logic [DL_W-1:0]  IDLE_RESET = 64'd1000000000;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TIMER_SLOTS - 1);

    // input item codes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ARM    = 2'd1;
    localparam logic [1:0] MODE_CANCEL = 2'd2;

    // register index (paddr[3])
    localparam logic REG_ENABLE    = 1'b0;
    localparam logic REG_IDLE_WAIT = 1'b1;

    typedef enum logic [1:0] {
        SCAN_PLAIN  = 2'd0,  // every valid slot takes part
        SCAN_REMOVE = 2'd1,  // drop slots with the item's id, rest take part
        SCAN_MATCH  = 2'd2   // only slots with the item's id take part
    } scan_kind_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        scan_kind_t kind;
        logic       clear_best;
        logic       emit_fired;
        logic       emit_close;
        logic       do_insert;
        logic       set_cand;
        logic       upd_wait;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_busy;
        logic scan_done;
        logic best_found;
        logic best_expired;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== rtl/core/mtdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mtdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                            clk,
    input  logic                                            we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr,
    input  logic [WIDTH-1:0]                                wdata,
    input  logic                                            re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr,
    output logic [WIDTH-1:0]                                rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mtdt_ctrl.sv =====
// Sequencing state machine of the timer table.
module mtdt_ctrl
    import mtdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_mode,
    input  logic       enable,
    input  dp_sts_t    sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_FIRE   = 7'b0001000,
        S_INSERT = 7'b0010000,
        S_WAIT   = 7'b0100000,
        S_CLOSE  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_TICK;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        cmd.kind   = SCAN_PLAIN;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    mode_next = in_mode;
                    case (in_mode)
                        MODE_TICK:
                        begin
                            if (enable)
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_CLOSE;
                            end
                        end
                        MODE_ARM:
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.kind       = SCAN_REMOVE;
                            state_next     = S_SCAN;
                        end
                        MODE_CANCEL:
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.kind       = SCAN_MATCH;
                            state_next     = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_CLOSE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                case (mode_reg)
                    MODE_CANCEL:
                    begin
                        cmd.clear_best = 1'b1;
                        state_next     = S_CLOSE;
                    end
                    MODE_ARM:
                    begin
                        if (enable && sts.best_found && sts.best_expired)
                        begin
                            state_next = S_FIRE;
                        end
                        else
                        begin
                            state_next = S_INSERT;
                        end
                    end
                    MODE_TICK:
                    begin
                        if (sts.best_found && sts.best_expired)
                        begin
                            state_next = S_FIRE;
                        end
                        else
                        begin
                            cmd.set_cand = 1'b1;
                            state_next   = S_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_CLOSE;
                    end
                endcase
            end
            S_FIRE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_fired = 1'b1;
                    cmd.clear_best = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_INSERT:
            begin
                cmd.do_insert = 1'b1;
                state_next    = enable ? S_WAIT : S_CLOSE;
            end
            S_WAIT:
            begin
                cmd.upd_wait = 1'b1;
                state_next   = S_CLOSE;
            end
            S_CLOSE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_close = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_fired || cmd.emit_close) |-> sts.out_free)
        else $error("result emitted while output register still occupied");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_start |-> !sts.scan_busy)
        else $error("scan started while previous scan still running");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new transaction taken before closing result");
`endif

endmodule

// ===== rtl/core/mtdt_dp.sv =====
// Slot storage, scan unit, deadline arithmetic and output register of the timer table.
module mtdt_dp
    import mtdt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic [ID_W-1:0]     in_timer_id,
    input  logic [DELAY_W-1:0]  in_delay_ms,
    input  logic [DL_W-1:0]     in_now_ns,
    input  logic [DL_W-1:0]     idle_wait_ns,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                fired_valid,
    output logic [ID_W-1:0]     fired_id,
    output logic [DL_W-1:0]     next_wait_ns,
    output logic                table_full,
    output logic                last
);

    // item payload
    logic [ID_W-1:0]    tid_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [DL_W-1:0]    now_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DL_W-1:0]    dl_reg;
    logic [DL_W:0]      dl_sum;

    // slot state
    logic [TIMER_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic                   ram_we;
    logic [ENTRY_W-1:0]     ram_rdata;

    // scan unit
    logic              scan_busy_reg;
    logic [SLOT_W-1:0] scan_cnt_reg;
    logic              pv_reg;
    logic [SLOT_W-1:0] pidx_reg;
    scan_kind_t        kind_reg;
    logic              best_found_reg;
    logic [SLOT_W-1:0] best_idx_reg;
    logic [DL_W-1:0]   best_dl_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [DL_W-1:0]   rd_dl;
    logic [ID_W-1:0]   rd_id;
    logic              rd_live, rd_match, rd_take;

    // free slot search
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;

    // wait
    logic            cand_valid_reg;
    logic [DL_W-1:0] cand_reg;
    logic [DL_W-1:0] cur_wait_reg;
    logic            full_reg;

    logic            out_valid_reg;
    logic            fired_valid_reg;
    logic [ID_W-1:0] fired_id_reg;
    logic [DL_W-1:0] next_wait_reg;
    logic            table_full_reg;
    logic            last_reg;

    // deadline = now + delay * 1e6, saturating
    assign dl_sum = {1'b0, now_reg} + {1'b0, DL_W'(prod_reg)};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tid_reg   <= in_timer_id;
            delay_reg <= in_delay_ms;
            now_reg   <= in_now_ns;
        end
        prod_reg <= PROD_W'(delay_reg) * PROD_W'(NS_PER_MS);
        dl_reg   <= dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0];
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign ram_we = cmd.do_insert && free_found;

    mtdt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata ({tid_reg, dl_reg}),
        .re    (scan_busy_reg),
        .raddr (scan_cnt_reg),
        .rdata (ram_rdata)
    );

    assign rd_dl    = ram_rdata[DL_W-1:0];
    assign rd_id    = ram_rdata[ENTRY_W-1:DL_W];
    assign rd_live  = pv_reg && slot_valid_reg[pidx_reg];
    assign rd_match = (rd_id == tid_reg);

    always_comb
    begin
        case (kind_reg)
            SCAN_REMOVE: rd_take = rd_live && !rd_match;
            SCAN_MATCH:  rd_take = rd_live && rd_match;
            default:     rd_take = rd_live;
        endcase
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (rd_live && rd_match && (kind_reg == SCAN_REMOVE))
        begin
            slot_valid_next[pidx_reg] = 1'b0;
        end
        if (cmd.clear_best && best_found_reg)
        begin
            slot_valid_next[best_idx_reg] = 1'b0;
        end
        if (ram_we)
        begin
            slot_valid_next[free_idx] = 1'b1;
        end
    end

    // scan control and running minimum (strict less keeps the lower slot on a tie)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            scan_busy_reg  <= 1'b0;
            scan_cnt_reg   <= '0;
            pv_reg         <= 1'b0;
            kind_reg       <= SCAN_PLAIN;
            best_found_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            pv_reg         <= scan_busy_reg;
            if (cmd.scan_start)
            begin
                scan_busy_reg  <= 1'b1;
                scan_cnt_reg   <= '0;
                kind_reg       <= cmd.kind;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (scan_busy_reg)
                begin
                    if (scan_cnt_reg == LAST_SLOT)
                    begin
                        scan_busy_reg <= 1'b0;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                if (rd_take && (!best_found_reg || (rd_dl < best_dl_reg)))
                begin
                    best_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= scan_cnt_reg;
        if (rd_take && (!best_found_reg || (rd_dl < best_dl_reg)))
        begin
            best_idx_reg <= pidx_reg;
            best_dl_reg  <= rd_dl;
            best_id_reg  <= rd_id;
        end
    end

    // earliest deadline candidate for the wait
    always_ff @(posedge clk)
    begin
        if (cmd.set_cand)
        begin
            cand_valid_reg <= best_found_reg;
            cand_reg       <= best_dl_reg;
        end
        else if (cmd.do_insert)
        begin
            if (free_found && (!best_found_reg || (dl_reg < best_dl_reg)))
            begin
                cand_valid_reg <= 1'b1;
                cand_reg       <= dl_reg;
            end
            else
            begin
                cand_valid_reg <= best_found_reg;
                cand_reg       <= best_dl_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_wait_reg  <= IDLE_RESET;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd_wait)
            begin
                cur_wait_reg <= (cand_valid_reg && (cand_reg > now_reg)) ?
                                (cand_reg - now_reg) : idle_wait_ns;
            end
            if (cmd.load)
            begin
                full_reg <= 1'b0;
            end
            else if (cmd.do_insert)
            begin
                full_reg <= !free_found;
            end
            if (cmd.emit_fired || cmd.emit_close)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_fired)
        begin
            fired_valid_reg <= 1'b1;
            fired_id_reg    <= best_id_reg;
            next_wait_reg   <= '0;
            table_full_reg  <= 1'b0;
            last_reg        <= 1'b0;
        end
        else if (cmd.emit_close)
        begin
            fired_valid_reg <= 1'b0;
            fired_id_reg    <= '0;
            next_wait_reg   <= cur_wait_reg;
            table_full_reg  <= full_reg;
            last_reg        <= 1'b1;
        end
    end

    assign sts.scan_busy    = scan_busy_reg;
    assign sts.scan_done    = pv_reg && (pidx_reg == LAST_SLOT);
    assign sts.best_found   = best_found_reg;
    assign sts.best_expired = (best_dl_reg <= now_reg);
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign fired_valid  = fired_valid_reg;
    assign fired_id     = fired_id_reg;
    assign next_wait_ns = next_wait_reg;
    assign table_full   = table_full_reg;
    assign last         = last_reg;

endmodule

// ===== rtl/core/multi_timer_deadline_table.sv =====
// Top level of the one-shot timer deadline table: configuration registers and wiring.
//
// Use: up to 16 one-shot timers, each an id with an absolute deadline in ns.
// Input channel (in_valid/in_ready) takes one transaction: mode tick, arm or
// cancel, with timer_id, delay_ms and now_ns. Output channel (out_valid/
// out_ready) returns one transaction per expired timer (fired_valid set,
// ascending deadline, lower slot first on a tie) and then a closing one with
// last set, carrying next_wait_ns and table_full.
// Throughput: one item at a time. Every arm, cancel or enabled tick makes
// one pass of the slot RAM, one slot read per cycle, and each fired timer
// costs a further pass; a disabled tick or unused mode makes no pass.
// The pass length is set by the single read port of the slot RAM.
// Output: a registered stage holds one result; the next input transaction is
// taken as soon as the closing result sits in it. If the receiver stalls,
// the sequencer holds its next result back until the stage is free.
// Reset (rst_n, async): all slots empty, enable clear, idle wait and
// current wait 1e9 ns. Configuration via APB: enable at 0x0, idle_wait_ns
// at 0x8; write only while the block is idle.
module multi_timer_deadline_table
    import mtdt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    // input items
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [ID_W-1:0]     timer_id,
    input  logic [DELAY_W-1:0]  delay_ms,
    input  logic [DL_W-1:0]     now_ns,
    // results
    output logic                out_valid,
    input  logic                out_ready,
    output logic                fired_valid,
    output logic [ID_W-1:0]     fired_id,
    output logic [DL_W-1:0]     next_wait_ns,
    output logic                table_full,
    output logic                last
);

    logic            enable_reg;
    logic [DL_W-1:0] idle_wait_reg;
    logic            cfg_write;
    dp_cmd_t         cmd;
    dp_sts_t         sts;

    // registers decoded on paddr[3]; low address bits are don't-care
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            idle_wait_reg <= IDLE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3])
                REG_ENABLE:    enable_reg    <= pwdata[0];
                REG_IDLE_WAIT: idle_wait_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_ENABLE:    prdata = {63'd0, enable_reg};
            REG_IDLE_WAIT: prdata = idle_wait_reg;
        endcase
    end

    // sequencer: one transaction at a time, fire loop, closing result
    mtdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_mode  (mode),
        .enable   (enable_reg),
        .sts      (sts),
        .cmd      (cmd)
    );

    // slot RAM, valid bits, scan, deadline maths, output stage
    mtdt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_timer_id  (timer_id),
        .in_delay_ms  (delay_ms),
        .in_now_ns    (now_ns),
        .idle_wait_ns (idle_wait_reg),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .fired_valid  (fired_valid),
        .fired_id     (fired_id),
        .next_wait_ns (next_wait_ns),
        .table_full   (table_full),
        .last         (last)
    );

endmodule

// ===== verif/tb_multi_timer_deadline_table.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the one-shot timer deadline table: directed and random commands.
module tb_multi_timer_deadline_table;
    import mtdt_pkg::*;

    // mode 3 is not decoded by the block; it must leave everything alone
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Slowest legal item: a scan, one further pass per fired timer, 17
    // results each held off by the receiver, plus the sender's gap; for
    // roughly 470 items the limit leaves a wide margin.
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_GAP      = 13;
    localparam int ID_POOL      = 24;

    localparam logic [DL_W-1:0] TIME_MAX = '1;

    typedef struct {
        logic [1:0]         mode;
        logic [ID_W-1:0]    id;
        logic [DELAY_W-1:0] delay;
        logic [DL_W-1:0]    now;
    } timer_cmd_t;

    typedef struct {
        logic               fired_valid;
        logic [ID_W-1:0]    fired_id;
        logic [DL_W-1:0]    next_wait;
        logic               table_full;
        logic               last;
    } timer_event_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          mode;
    logic [ID_W-1:0]     timer_id;
    logic [DELAY_W-1:0]  delay_ms;
    logic [DL_W-1:0]     now_ns;
    logic                out_valid;
    logic                out_ready;
    logic                fired_valid;
    logic [ID_W-1:0]     fired_id;
    logic [DL_W-1:0]     next_wait_ns;
    logic                table_full;
    logic                last;

    multi_timer_deadline_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .timer_id     (timer_id),
        .delay_ms     (delay_ms),
        .now_ns       (now_ns),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .fired_valid  (fired_valid),
        .fired_id     (fired_id),
        .next_wait_ns (next_wait_ns),
        .table_full   (table_full),
        .last         (last)
    );

    // ------------------------------------------------------------------
    // Shadow of the timer table, kept in step with every accepted command
    // ------------------------------------------------------------------
    logic               slot_busy     [TIMER_SLOTS];
    logic [DL_W-1:0]    slot_due      [TIMER_SLOTS];
    logic [ID_W-1:0]    slot_owner    [TIMER_SLOTS];
    logic [DL_W-1:0]    wait_now;
    logic               cfg_enable;
    logic [DL_W-1:0]    cfg_idle_wait;

    timer_cmd_t         cmd_q[$];       // commands not yet offered to the block
    timer_event_t       expected_q[$];  // results owed by the block, oldest first

    timer_cmd_t         drive_cmd;
    timer_event_t       want;
    logic [DL_W-1:0]    sim_now;        // running wall clock of the random sequences

    int                 in_gap;
    int                 out_gap;
    bit                 in_steady;
    bit                 out_steady;
    bit                 in_taken;
    int                 cmds_queued;
    int                 cmds_taken;
    int                 results_seen;
    int                 expiries_seen;
    int                 rejects_seen;
    int                 error_count;
    int                 cycle_count;

    always #2 clk = ~clk;

    // Slot holding the earliest deadline, lower slot on a tie; optionally
    // only slots owned by a given id. -1 when nothing qualifies.
    function automatic int earliest_slot(input logic by_id, input logic [ID_W-1:0] id);
        int best = -1;
        for (int i = 0; i < TIMER_SLOTS; i++)
            if (slot_busy[i] && (!by_id || slot_owner[i] == id))
                if (best < 0 || slot_due[i] < slot_due[best])
                    best = i;
        return best;
    endfunction

    // Every timer due at or before now expires, earliest first.
    task automatic fire_due(input logic [DL_W-1:0] now);
        int s;
        s = earliest_slot(1'b0, '0);
        while (s >= 0 && slot_due[s] <= now)
        begin
            expected_q.push_back('{1'b1, slot_owner[s], 64'd0, 1'b0, 1'b0});
            slot_busy[s] = 1'b0;
            s = earliest_slot(1'b0, '0);
        end
    endtask

    task automatic refresh_wait(input logic [DL_W-1:0] now);
        int s;
        s = earliest_slot(1'b0, '0);
        if (s >= 0 && slot_due[s] > now)
            wait_now = slot_due[s] - now;
        else
            wait_now = cfg_idle_wait;
    endtask

    task automatic predict_timer_events(input timer_cmd_t c);
        logic [DL_W:0]   delay_ns;
        logic [DL_W:0]   sum;
        logic [DL_W-1:0] due;
        int              slot;
        logic            full;
        slot = -1;
        full = 1'b0;
        case (c.mode)
            MODE_ARM:
            begin
                delay_ns = c.delay * NS_PER_MS;
                sum      = {1'b0, c.now} + delay_ns;
                // deadline saturates rather than wrapping
                due      = sum[DL_W] ? TIME_MAX : sum[DL_W-1:0];
                for (int i = 0; i < TIMER_SLOTS; i++)
                    if (slot_busy[i] && slot_owner[i] == c.id)
                        slot_busy[i] = 1'b0;
                if (cfg_enable)
                    fire_due(c.now);
                for (int i = 0; i < TIMER_SLOTS; i++)
                    if (!slot_busy[i] && slot < 0)
                        slot = i;
                if (slot >= 0)
                begin
                    slot_busy[slot]  = 1'b1;
                    slot_due[slot]   = due;
                    slot_owner[slot] = c.id;
                end
                else
                begin
                    full = 1'b1;
                end
                if (cfg_enable)
                    refresh_wait(c.now);
            end
            MODE_TICK:
            begin
                if (cfg_enable)
                begin
                    fire_due(c.now);
                    refresh_wait(c.now);
                end
            end
            MODE_CANCEL:
            begin
                // first match in deadline order, enabled or not
                slot = earliest_slot(1'b1, c.id);
                if (slot >= 0)
                    slot_busy[slot] = 1'b0;
            end
            default:
            begin
            end
        endcase
        expected_q.push_back('{1'b0, 32'd0, wait_now, full, 1'b1});
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(input logic [1:0] m, input logic [ID_W-1:0] id,
                            input logic [DELAY_W-1:0] d, input logic [DL_W-1:0] t);
        cmd_q.push_back('{m, id, d, t});
        cmds_queued++;
    endtask

    // APB write: setup phase, then access phase; called at a falling edge.
    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Block idle: every command taken and every result back, then a further
    // drain wait for good measure.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (cmds_taken != cmds_queued || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic queue_directed();
        push_cmd(MODE_TICK,   32'd0,          32'd0, 64'd0);     // empty table
        push_cmd(MODE_ARM,    32'd0,          32'd0, 64'd100);   // zero delay, due at once
        push_cmd(MODE_ARM,    32'hFFFF_FFFF,  32'd1, 64'd100);   // arm fires the stale one
        push_cmd(MODE_ARM,    32'd7,          32'd1, 64'd100);
        push_cmd(MODE_ARM,    32'd8,          32'd1, 64'd100);   // same deadline as all-ones id
        push_cmd(MODE_ARM,    32'd7,          32'd2, 64'd200);   // re-arm replaces id 7
        push_cmd(MODE_CANCEL, 32'd7,          32'd0, 64'd0);
        push_cmd(MODE_CANCEL, 32'h5555_AAAA,  32'd0, 64'd0);     // no such timer
        push_cmd(MODE_TICK,   32'd0,          32'd0, 64'd3_000_000); // tie: lower slot first
        push_cmd(MODE_UNUSED, 32'hFFFF_FFFF,  32'hFFFF_FFFF, TIME_MAX);
        // deadlines that overflow the 64-bit clock
        push_cmd(MODE_ARM,    32'd9,  32'hFFFF_FFFF, TIME_MAX);
        push_cmd(MODE_ARM,    32'd10, 32'd5,         64'hFFFF_FFFF_FFFF_0000);
        // fill the remaining slots, then one arm too many
        for (int k = 0; k < TIMER_SLOTS - 2; k++)
            push_cmd(MODE_ARM, 32'h100 + k, 32'd1000 + k, 64'd1 << 40);
        push_cmd(MODE_ARM,    32'h200, 32'd1, 64'd1 << 40);
        // every timer expires at once: the longest result burst
        push_cmd(MODE_TICK,   32'd0, 32'd0, TIME_MAX);
    endtask

    // Mostly plausible traffic: a small id pool, short delays and a clock
    // that moves forward, with bursts that fill the table. The rest is
    // noise: any mode, any id, any delay, time jumping about.
    task automatic queue_random(input int count);
        int           made;
        int           pick;
        int           burst;
        timer_cmd_t   c;
        made = 0;
        while (made < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
            begin
                c.delay = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 20);
                push_cmd(MODE_ARM, $urandom_range(0, ID_POOL - 1), c.delay, sim_now);
                made++;
            end
            else if (pick < 52)
            begin
                sim_now = sim_now + $urandom_range(0, 15_000_000);
                push_cmd(MODE_TICK, $urandom, $urandom, sim_now);
                made++;
            end
            else if (pick < 62)
            begin
                push_cmd(MODE_CANCEL, $urandom_range(0, ID_POOL - 1), $urandom, sim_now);
                made++;
            end
            else if (pick < 68)
            begin
                burst = $urandom_range(TIMER_SLOTS - 1, TIMER_SLOTS + 3);
                for (int k = 0; k < burst; k++)
                    push_cmd(MODE_ARM, 32'd100 + k, $urandom_range(50, 200), sim_now);
                sim_now = sim_now + 64'd250_000_000;
                push_cmd(MODE_TICK, '0, '0, sim_now);
                made += burst + 1;
            end
            else
            begin
                c.mode  = $urandom_range(0, 3);
                c.id    = $urandom_range(0, 1) ? $urandom : $urandom_range(0, ID_POOL - 1);
                c.delay = $urandom;
                case ($urandom_range(0, 3))
                    0:       c.now = {$urandom, $urandom};
                    1:       c.now = sim_now - $urandom_range(0, 50_000_000);
                    2:       c.now = TIME_MAX;
                    default: c.now = '0;
                endcase
                push_cmd(c.mode, c.id, c.delay, c.now);
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: one transaction at a time from cmd_q, random gaps
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        // hold valid and payload until the block takes the transaction
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                drive_cmd = cmd_q.pop_front();
                mode      <= drive_cmd.mode;
                timer_id  <= drive_cmd.id;
                delay_ms  <= drive_cmd.delay;
                now_ns    <= drive_cmd.now;
                in_valid  <= 1'b1;
                // now and then switch between gappy and back-to-back stretches
                if ($urandom_range(0, 29) == 0)
                    in_steady = !in_steady;
                in_gap = in_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
    end

    // Output back-pressure: a fresh stall length after every result
    always @(negedge clk)
    begin
        if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: register writes, accepted commands and results, all
    // sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[3] == REG_IDLE_WAIT)
                    cfg_idle_wait = pwdata;
                else
                    cfg_enable = pwdata[0];
            end

            if (in_valid && in_ready)
            begin
                predict_timer_events('{mode, timer_id, delay_ms, now_ns});
                cmds_taken++;
                in_taken = 1'b1;
            end

            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: fired_id %h, last %b", fired_id, last);
                    error_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (fired_valid !== want.fired_valid)
                    begin
                        $error("fired_valid: expected %b, got %b", want.fired_valid, fired_valid);
                        error_count++;
                    end
                    if (fired_id !== want.fired_id)
                    begin
                        $error("fired_id: expected %h, got %h", want.fired_id, fired_id);
                        error_count++;
                    end
                    if (next_wait_ns !== want.next_wait)
                    begin
                        $error("next_wait_ns: expected %0d, got %0d", want.next_wait, next_wait_ns);
                        error_count++;
                    end
                    if (table_full !== want.table_full)
                    begin
                        $error("table_full: expected %b, got %b", want.table_full, table_full);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, last);
                        error_count++;
                    end
                    if (want.fired_valid)
                        expiries_seen++;
                    if (want.table_full)
                        rejects_seen++;
                end
                if ($urandom_range(0, 29) == 0)
                    out_steady = !out_steady;
                out_gap = out_steady ? 0 : $urandom_range(0, MAX_GAP);
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("multi_timer_deadline_table: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence of the run: reset, directed checks, then four random
    // phases under different register settings
    // ------------------------------------------------------------------
    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        mode     = MODE_TICK;
        timer_id = '0;
        delay_ms = '0;
        now_ns   = '0;
        out_ready = 1'b0;
        in_gap = 0;
        out_gap = 0;
        in_steady = 1'b0;
        out_steady = 1'b0;
        in_taken = 1'b0;
        cmds_queued = 0;
        cmds_taken = 0;
        results_seen = 0;
        expiries_seen = 0;
        rejects_seen = 0;
        error_count = 0;
        // state after reset
        for (int i = 0; i < TIMER_SLOTS; i++)
        begin
            slot_busy[i]  = 1'b0;
            slot_due[i]   = '0;
            slot_owner[i] = '0;
        end
        cfg_enable    = 1'b0;
        cfg_idle_wait = IDLE_RESET;
        wait_now      = IDLE_RESET;
        sim_now       = {24'd0, 8'($urandom_range(0, 255)), $urandom};

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, running with the reset idle wait
        apb_write({REG_ENABLE, 3'b000}, 64'd1);
        apb_write({REG_IDLE_WAIT, 3'b000}, IDLE_RESET);
        queue_directed();
        wait_drained();

        // enabled, arbitrary idle wait
        apb_write({REG_IDLE_WAIT, 3'b000}, {$urandom, $urandom});
        queue_random(185);
        wait_drained();

        // disabled, zero idle wait: only arm and cancel change the table
        apb_write({REG_ENABLE, 3'b000}, 64'd0);
        apb_write({REG_IDLE_WAIT, 3'b000}, 64'd0);
        queue_random(55);
        wait_drained();

        // enabled again with the largest idle wait
        apb_write({REG_ENABLE, 3'b000}, 64'd1);
        apb_write({REG_IDLE_WAIT, 3'b000}, TIME_MAX);
        queue_random(140);
        wait_drained();

        // back to the default idle wait
        apb_write({REG_IDLE_WAIT, 3'b000}, IDLE_RESET);
        queue_random(55);
        wait_drained();

        $display("Covered %0d timer commands under five register settings,", cmds_taken);
        $display("checking %0d results: %0d expiries and %0d full-table rejections.",
                 results_seen, expiries_seen, rejects_seen);
        if (error_count == 0)
            $display("multi_timer_deadline_table: match");
        else
            $display("multi_timer_deadline_table: mismatch");
        $finish;
    end

endmodule
